>>> hdl/cursor_edit_buffer_defines.svh
// Assertion macros shared by the cursor edit buffer checker.
`ifndef CURSOR_EDIT_BUFFER_DEFINES_SVH
`define CURSOR_EDIT_BUFFER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CEB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CEB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ceb_pkg.sv
// Package for the cursor edit buffer: command codes, item and control types.
package ceb_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_LEFT   = 3'd1,
    CMD_RIGHT  = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4
  } ceb_cmd_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_in;
    logic [5:0] read_index;
  } ceb_in_t;

  typedef struct packed {
    logic [7:0] removed_char;
    logic       removed_valid;
    logic [7:0] read_char;
    logic [6:0] cursor_pos;
    logic [6:0] text_length;
    logic       full_flag;
  } ceb_out_t;

  // Shift command broadcast to every cell.
  typedef struct packed {
    logic ins;  // open a gap at the cursor and load the new character
    logic del;  // close the gap left of the cursor
  } ceb_shift_t;

endpackage

>>> hdl/ceb_cell.sv
// One character cell of the buffer row: holds a byte, shifts with its neighbors.
module ceb_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7,
  parameter int unsigned IW  = 6
) (
  input  logic               clk_i,
  input  ceb_pkg::ceb_shift_t ctrl_i,
  input  logic [CW-1:0]      cur_i,
  input  logic [IW-1:0]      sel_i,
  input  logic [7:0]         char_i,
  input  logic [7:0]         left_i,
  input  logic [7:0]         right_i,
  output logic [7:0]         data_o,
  output logic [7:0]         tap_o
);

  localparam logic [CW-1:0] MY_POS   = CW'(IDX);
  localparam logic [CW:0]   NEXT_POS = (CW+1)'(IDX + 1);
  localparam logic [IW-1:0] MY_ADDR  = IW'(IDX);

  logic [7:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (MY_POS > cur_i) begin
        data_d = left_i;
      end else if (MY_POS == cur_i) begin
        data_d = char_i;
      end
    end else if (ctrl_i.del) begin
      // cells from cursor-1 upward pull from the right
      if ({1'b0, cur_i} <= NEXT_POS) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tap_o  = (sel_i == MY_ADDR) ? data_q : 8'h00;

endmodule

>>> hdl/cursor_edit_buffer.sv
// Cursor edit buffer top level: cell row, cursor/length control, result register.
// A result item is registered, valid in the cycle after its command is accepted.
// Throughput: one item per cycle unless stalled; insert, delete take one row shift.
// Input stall rises only while a finished result waits on a stalled output.
// Reset clears length, cursor and the output valid; cell bytes are not cleared
//   and are read only at positions below the length, which were always written.
module cursor_edit_buffer #(
  parameter int unsigned CAPACITY = ceb_pkg::CAPACITY_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ceb_pkg::ceb_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ceb_pkg::ceb_out_t out_data_o
);

  // CW holds a count up to CAPACITY, IW addresses a cell.
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned RW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  // control state
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cur_q, cur_d;
  logic          out_valid_q;
  ceb_pkg::ceb_out_t out_q, out_d;

  logic accept;
  logic ins_ok, full, del_ok, rd_ok;
  logic [CW-1:0] cur_m1;
  logic [IW-1:0] sel;
  ceb_pkg::ceb_shift_t shift;

  // cell row wiring
  logic [7:0] cell_data [CAPACITY];
  logic [7:0] cell_tap  [CAPACITY];
  logic [7:0] tap_or;

  // Output register frees up when empty or being taken this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Command decode against the current length and cursor.
  assign cur_m1 = cur_q - CW'(1);
  assign ins_ok = (in_data_i.cmd == ceb_pkg::CMD_INSERT) && (count_q < CAP_CNT);
  assign full   = (in_data_i.cmd == ceb_pkg::CMD_INSERT) && (count_q >= CAP_CNT);
  assign del_ok = (in_data_i.cmd == ceb_pkg::CMD_DELETE) && (cur_q != '0);
  assign rd_ok  = (in_data_i.cmd == ceb_pkg::CMD_READ) &&
                  (RW'(in_data_i.read_index) < RW'(count_q));

  // One shared tap select: delete looks left of the cursor, read at its index.
  // Read index is in range whenever rd_ok holds, so truncation is safe.
  assign sel = del_ok ? cur_m1[IW-1:0] : IW'(in_data_i.read_index);

  assign shift.ins = accept && ins_ok;
  assign shift.del = accept && del_ok;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [7:0] left, right;
    if (g == 0) begin : g_first
      assign left = 8'h00;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = 8'h00;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    ceb_cell #(
      .IDX (g),
      .CW  (CW),
      .IW  (IW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (shift),
      .cur_i   (cur_q),
      .sel_i   (sel),
      .char_i  (in_data_i.char_in),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .tap_o   (cell_tap[g])
    );
  end

  // At most one cell taps nonzero; OR them together.
  always_comb begin
    tap_or = 8'h00;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  // Next cursor and length.
  always_comb begin
    count_d = count_q;
    cur_d   = cur_q;
    case (in_data_i.cmd)
      ceb_pkg::CMD_INSERT: begin
        if (ins_ok) begin
          count_d = count_q + CW'(1);
          cur_d   = cur_q + CW'(1);
        end
      end
      ceb_pkg::CMD_LEFT: begin
        if (cur_q != '0) cur_d = cur_m1;
      end
      ceb_pkg::CMD_RIGHT: begin
        if (cur_q < count_q) cur_d = cur_q + CW'(1);
      end
      ceb_pkg::CMD_DELETE: begin
        if (del_ok) begin
          count_d = count_q - CW'(1);
          cur_d   = cur_m1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result item.
  always_comb begin
    out_d.removed_char  = del_ok ? tap_or : 8'h00;
    out_d.removed_valid = del_ok;
    out_d.read_char     = rd_ok ? tap_or : 8'h00;
    out_d.cursor_pos    = 7'(cur_d);
    out_d.text_length   = 7'(count_d);
    out_d.full_flag     = full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
        cur_q   <= cur_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/ceb_checker.sv
// Port-level checker for the cursor edit buffer, bound to the top level.
`include "cursor_edit_buffer_defines.svh"

module ceb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input ceb_pkg::ceb_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ceb_pkg::ceb_out_t out_data_o
);

  logic ins_acc;

  // insert item taken this cycle
  assign ins_acc = in_valid_i && !in_stall_o && (in_data_i.cmd == ceb_pkg::CMD_INSERT);

  // a stalled result holds
  `CEB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result item changed")

  // cursor never passes the end of the text
  `CEB_ASSERT_IMPL(a_cur_le_len, out_valid_o, out_data_o.cursor_pos <= out_data_o.text_length, "cursor beyond text length")

  // a delete result carries no read byte and no full flag
  `CEB_ASSERT_IMPL(a_del_excl, out_valid_o && out_data_o.removed_valid, !out_data_o.full_flag && out_data_o.read_char == 8'h00, "delete result mixed with other flags")

  // a refused insert removes and reads nothing
  `CEB_ASSERT_IMPL(a_full_excl, out_valid_o && out_data_o.full_flag, !out_data_o.removed_valid && out_data_o.removed_char == 8'h00 && out_data_o.read_char == 8'h00, "full result mixed with other fields")

  // an insert, taken or refused, leaves a nonempty line
  `CEB_ASSERT_NEXT(a_ins_len, ins_acc, out_valid_o && out_data_o.text_length != '0, "insert left empty line")

endmodule

bind cursor_edit_buffer ceb_checker u_ceb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the cursor edit buffer: queue-fed driver, monitor, line model.
module tb;

  localparam int CAP        = ceb_pkg::CAPACITY_DEF;
  localparam int RAND_ITEMS = 1650;
  localparam int HOLD_LEN   = 300;     // long receiver hold-off, in cycles
  localparam int DRAIN_WAIT = 4;       // registered result, plus margin
  localparam int CYCLE_MAX  = 200000;

  // One queued keystroke: the command item, a drain request and its idling phase.
  typedef struct {
    ceb_pkg::ceb_in_t item;
    bit      drain;   // hold off until every expected result has arrived
    int      phase;   // 0: sender idles less, 1: receiver idles less, 2: no idling
  } keystroke_t;

  typedef enum int {
    MODE_TYPING,
    MODE_EDITING,
    MODE_ERASING
  } edit_mode_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  ceb_pkg::ceb_in_t  in_data = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  ceb_pkg::ceb_out_t out_data;

  keystroke_t        keystrokes[$];
  ceb_pkg::ceb_out_t pending_results[$];

  // Line model state.
  logic [7:0] line_text [CAP];
  logic [6:0] line_len = '0;
  logic [6:0] line_cursor = '0;

  int error_cnt = 0;
  int accepted_cnt = 0;
  int cycle_cnt = 0;
  int cur_phase = 0;
  int hold_at = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  cursor_edit_buffer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one command to the model line; returns the result item it should produce.
  function automatic ceb_pkg::ceb_out_t edit_line(ceb_pkg::ceb_in_t c);
    ceb_pkg::ceb_out_t r;
    int i;
    r = '0;
    case (c.cmd)
      ceb_pkg::CMD_INSERT: begin
        if (line_len >= CAP) begin
          r.full_flag = 1'b1;
        end else begin
          // open a gap at the cursor
          for (i = int'(line_len); i > int'(line_cursor); i--) line_text[i] = line_text[i-1];
          line_text[line_cursor] = c.char_in;
          line_len++;
          line_cursor++;
        end
      end
      ceb_pkg::CMD_LEFT: begin
        if (line_cursor > 0) line_cursor--;
      end
      ceb_pkg::CMD_RIGHT: begin
        if (line_cursor < line_len) line_cursor++;
      end
      ceb_pkg::CMD_DELETE: begin
        // backspace: drop the byte left of the cursor and close the gap
        if (line_cursor > 0) begin
          r.removed_char  = line_text[line_cursor-1];
          r.removed_valid = 1'b1;
          for (i = int'(line_cursor) - 1; i + 1 < int'(line_len); i++)
            line_text[i] = line_text[i+1];
          line_len--;
          line_cursor--;
        end
      end
      ceb_pkg::CMD_READ: begin
        if (c.read_index < line_len) r.read_char = line_text[c.read_index];
      end
      default: ;  // unused codes leave the line alone
    endcase
    r.cursor_pos  = line_cursor;
    r.text_length = line_len;
    return r;
  endfunction

  task automatic queue_key(logic [2:0] cmd, logic [7:0] ch, logic [5:0] idx,
                           bit drain, int phase);
    keystroke_t k;
    k.item.cmd        = cmd;
    k.item.char_in    = ch;
    k.item.read_index = idx;
    k.drain           = drain;
    k.phase           = phase;
    keystrokes.push_back(k);
  endtask

  // Picks a command code weighted by the kind of editing going on.
  function automatic logic [2:0] pick_cmd(edit_mode_e mode);
    int roll;
    roll = $urandom_range(99);
    case (mode)
      MODE_TYPING: begin
        if (roll < 70) return ceb_pkg::CMD_INSERT;
        if (roll < 78) return ceb_pkg::CMD_LEFT;
        if (roll < 83) return ceb_pkg::CMD_RIGHT;
        if (roll < 88) return ceb_pkg::CMD_DELETE;
        return ceb_pkg::CMD_READ;
      end
      MODE_ERASING: begin
        if (roll < 60) return ceb_pkg::CMD_DELETE;
        if (roll < 70) return ceb_pkg::CMD_LEFT;
        if (roll < 80) return ceb_pkg::CMD_RIGHT;
        if (roll < 95) return ceb_pkg::CMD_READ;
        return ceb_pkg::CMD_INSERT;
      end
      default: begin
        if (roll < 4) return 3'(ceb_pkg::CMD_READ) + 3'($urandom_range(1, 3));
        if (roll < 25) return ceb_pkg::CMD_INSERT;
        if (roll < 45) return ceb_pkg::CMD_LEFT;
        if (roll < 65) return ceb_pkg::CMD_RIGHT;
        if (roll < 80) return ceb_pkg::CMD_DELETE;
        return ceb_pkg::CMD_READ;
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      error_cnt++;
    end
  endtask

  // Driver: offers the next queued item; a stalled item is held unchanged.
  always @(posedge clk or negedge rst_n) begin
    logic             nv;
    ceb_pkg::ceb_in_t nd;
    int               idle_pct;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      nv = in_valid;
      nd = in_data;
      if (in_valid && !in_stall) begin
        pending_results.push_back(edit_line(in_data));
        accepted_cnt++;
        nv = 1'b0;
      end
      if (!nv && keystrokes.size() > 0) begin
        idle_pct = (keystrokes[0].phase == 0) ? 26 : (keystrokes[0].phase == 1) ? 63 : 0;
        if (keystrokes[0].drain && pending_results.size() > 0) begin
          // pause until the block has answered everything
        end else if (int'($urandom_range(99)) < idle_pct) begin
          // idle this cycle
        end else begin
          nv        = 1'b1;
          nd        = keystrokes[0].item;
          cur_phase = keystrokes[0].phase;
          keystrokes.pop_front();
        end
      end
      in_valid <= nv;
      in_data  <= nd;
    end
  end

  // Long receiver hold-off counter: starts once, after enough items went in.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= hold_at) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // Monitor: checks each accepted result against the oldest expectation, drives stall.
  always @(posedge clk or negedge rst_n) begin
    ceb_pkg::ceb_out_t exp_r;
    logic              ns;
    int                idle_pct;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result item with no command waiting");
          error_cnt++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("removed_char",  exp_r.removed_char,  out_data.removed_char);
          check_field("removed_valid", 8'(exp_r.removed_valid), 8'(out_data.removed_valid));
          check_field("read_char",     exp_r.read_char,     out_data.read_char);
          check_field("cursor_pos",    8'(exp_r.cursor_pos),  8'(out_data.cursor_pos));
          check_field("text_length",   8'(exp_r.text_length), 8'(out_data.text_length));
          check_field("full_flag",     8'(exp_r.full_flag),   8'(out_data.full_flag));
        end
      end
      idle_pct = (cur_phase == 0) ? 63 : (cur_phase == 1) ? 26 : 0;
      if (hold_left > 0) begin
        // long hold-off while the sender keeps offering: the block backs up
        ns = 1'b1;
      end else begin
        ns = (int'($urandom_range(99)) < idle_pct);
      end
      out_stall <= ns;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int         n;
    int         seg_len;
    int         phase;
    bit         drain;
    edit_mode_e mode;
    logic [2:0] c;

    foreach (line_text[i]) line_text[i] = '0;

    // Directed: empty-line corners, both byte extremes, clamps, mid-line edits,
    // read past the length, and the unused command codes.
    queue_key(ceb_pkg::CMD_READ,   8'h00, 6'd0,  1'b0, 0);  // read on empty line
    queue_key(ceb_pkg::CMD_DELETE, 8'hFF, 6'h3F, 1'b0, 0);  // backspace at cursor 0
    queue_key(ceb_pkg::CMD_LEFT,   8'h00, 6'd0,  1'b0, 0);  // left clamp at 0
    queue_key(ceb_pkg::CMD_RIGHT,  8'h00, 6'd0,  1'b0, 0);  // right clamp on empty line
    queue_key(ceb_pkg::CMD_INSERT, 8'h00, 6'h3F, 1'b0, 0);
    queue_key(ceb_pkg::CMD_INSERT, 8'hFF, 6'd0,  1'b0, 0);
    queue_key(ceb_pkg::CMD_INSERT, 8'hA5, 6'h2A, 1'b0, 0);
    queue_key(ceb_pkg::CMD_RIGHT,  8'h00, 6'd0,  1'b0, 0);  // right clamp at length
    queue_key(ceb_pkg::CMD_LEFT,   8'h00, 6'd0,  1'b0, 0);
    queue_key(ceb_pkg::CMD_LEFT,   8'h00, 6'd0,  1'b0, 0);
    queue_key(ceb_pkg::CMD_INSERT, 8'h5A, 6'h15, 1'b0, 0);  // insert mid-line
    queue_key(ceb_pkg::CMD_READ,   8'h00, 6'd0,  1'b0, 0);
    queue_key(ceb_pkg::CMD_READ,   8'h00, 6'd1,  1'b0, 0);
    queue_key(ceb_pkg::CMD_READ,   8'h00, 6'd2,  1'b0, 0);
    queue_key(ceb_pkg::CMD_READ,   8'h00, 6'd3,  1'b0, 0);
    queue_key(ceb_pkg::CMD_READ,   8'hFF, 6'd4,  1'b0, 0);  // just past the length
    queue_key(ceb_pkg::CMD_READ,   8'h00, 6'h3F, 1'b0, 0);  // far past the length
    queue_key(ceb_pkg::CMD_DELETE, 8'h00, 6'd0,  1'b0, 0);  // backspace mid-line
    queue_key(ceb_pkg::CMD_LEFT,   8'h00, 6'd0,  1'b0, 0);
    queue_key(ceb_pkg::CMD_LEFT,   8'h00, 6'd0,  1'b0, 0);
    queue_key(ceb_pkg::CMD_LEFT,   8'h00, 6'd0,  1'b0, 0);
    queue_key(ceb_pkg::CMD_DELETE, 8'h00, 6'd0,  1'b0, 0);  // backspace at 0, line not empty
    queue_key(3'(ceb_pkg::CMD_READ) + 3'd1, 8'hFF, 6'h3F, 1'b0, 0);
    queue_key(3'(ceb_pkg::CMD_READ) + 3'd2, 8'h00, 6'd0,  1'b0, 0);
    queue_key(3'(ceb_pkg::CMD_READ) + 3'd3, 8'hFF, 6'h3F, 1'b0, 0);

    // Random: segments of typing, editing and erasing with random content.
    // The first segment is plain typing past capacity so the full case is hit early.
    hold_at = keystrokes.size() + 1200;
    n = 0;
    while (n < RAND_ITEMS) begin
      if (n == 0) begin
        seg_len = CAP + 6;
      end else begin
        seg_len = $urandom_range(8, 80);
      end
      case ($urandom_range(99) / 35)
        0:       mode = MODE_TYPING;
        1:       mode = MODE_EDITING;
        default: mode = MODE_ERASING;
      endcase
      for (int k = 0; k < seg_len && n < RAND_ITEMS; k++) begin
        phase = (n < RAND_ITEMS / 3) ? 0 : (n < 2 * RAND_ITEMS / 3) ? 1 : 2;
        // drain at each phase change and now and then
        drain = (n == 0) || (n == RAND_ITEMS / 3) || (n == 2 * RAND_ITEMS / 3) ||
                ($urandom_range(99) == 0);
        c = (n == 0 || k < seg_len && n < CAP + 6) ? ceb_pkg::CMD_INSERT : pick_cmd(mode);
        queue_key(c, 8'($urandom_range(255)), 6'($urandom_range(63)), drain, phase);
        n++;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (keystrokes.size() > 0 || in_valid || pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_cnt == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
